[sv/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, sampled on clk, disabled in reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define BAR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BAR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/bar_pkg.sv]
// ---------------------------------------------------------------------------
// bar_pkg
// shared types and constants of the button auto-repeat block
// ---------------------------------------------------------------------------
package bar_pkg;

    localparam int MASK_W    = 16;  // button mask width
    localparam int SAMPLE_W  = 48;  // timestamp field width
    localparam int DUR_W     = 24;  // duration register width
    localparam int IDX_W     = 4;   // combo index width
    localparam int CFG_IDX_W = 8;   // configuration index width

    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT       = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COMBO_FIRST  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COMBO_SECOND = 8'd3;

    localparam logic [DUR_W-1:0] LONG_PRESS_RESET   = 24'd400000;
    localparam logic [DUR_W-1:0] REPEAT_RESET       = 24'd80000;
    localparam logic [IDX_W-1:0] COMBO_FIRST_RESET  = 4'd0;
    localparam logic [IDX_W-1:0] COMBO_SECOND_RESET = 4'd1;

    // timing settings seen by every lane
    typedef struct packed {
        logic [DUR_W-1:0] long_press_us;
        logic [DUR_W-1:0] repeat_us;
    } bar_cfg_t;

    // events one lane reports for one sample
    typedef struct packed {
        logic press;
        logic rep;
    } bar_evt_t;

endpackage

[sv/bar_lane.sv]
// ---------------------------------------------------------------------------
// bar_lane
// press / long-press / repeat tracker of one button
// ---------------------------------------------------------------------------
module bar_lane
    import bar_pkg::*;
#(
    parameter int TIME_WIDTH = 48
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,      // sample accepted and not suppressed
    input  logic                  down,
    input  logic [TIME_WIDTH-1:0] t,
    input  bar_cfg_t              cfg,
    output bar_evt_t              evt
);

    logic                  held_reg, held_next;
    logic                  long_reg, long_next;
    logic [TIME_WIDTH-1:0] press_time_reg, press_time_next;
    logic [TIME_WIDTH-1:0] last_fire_reg, last_fire_next;

    logic [TIME_WIDTH-1:0] base;
    logic [TIME_WIDTH-1:0] dur;
    logic [TIME_WIDTH-1:0] diff;
    logic                  later;

    // one shared subtract: repeat mode compares against last fire, else press time
    assign base  = long_reg ? last_fire_reg : press_time_reg;
    assign dur   = {{(TIME_WIDTH-DUR_W){1'b0}}, (long_reg ? cfg.repeat_us : cfg.long_press_us)};
    assign diff  = t - base;
    assign later = (t > base) && (diff > dur);

    always_comb
    begin
        held_next       = held_reg;
        long_next       = long_reg;
        press_time_next = press_time_reg;
        last_fire_next  = last_fire_reg;
        evt             = '0;
        if (en)
        begin
            if (!down)
            begin
                held_next = 1'b0;
                long_next = 1'b0;
            end
            else if (!held_reg)
            begin
                held_next       = 1'b1;
                press_time_next = t;
                evt.press       = 1'b1;
            end
            else if (long_reg)
            begin
                if (later)
                begin
                    last_fire_next = t;
                    evt.rep        = 1'b1;
                end
            end
            else if (later)
            begin
                long_next      = 1'b1;
                last_fire_next = press_time_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 1'b0;
            long_reg <= 1'b0;
        end
        else
        begin
            held_reg <= held_next;
            long_reg <= long_next;
        end
    end

    always_ff @(posedge clk)
    begin
        press_time_reg <= press_time_next;
        last_fire_reg  <= last_fire_next;
    end

endmodule

[sv/bar_merge.sv]
// ---------------------------------------------------------------------------
// bar_merge
// gathers lane events into the result word and holds it in the output register
// ---------------------------------------------------------------------------
module bar_merge
    import bar_pkg::*;
#(
    parameter int BUTTON_COUNT = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  logic                           suppressed,
    input  bar_evt_t [BUTTON_COUNT-1:0]    evt,
    output logic                           slot_free,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [2*MASK_W-1:0]            m_tdata,
    output logic [0:0]                     m_tuser
);

    logic [MASK_W-1:0]   press_mask;
    logic [MASK_W-1:0]   repeat_mask;
    logic                valid_reg, valid_next;
    logic [2*MASK_W-1:0] data_reg;
    logic                supp_reg;

    // lanes past the mask width never report
    for (genvar i = 0; i < MASK_W; i++)
    begin : g_bit
        if (i < BUTTON_COUNT)
        begin : g_lane
            assign press_mask[i]  = evt[i].press;
            assign repeat_mask[i] = evt[i].rep;
        end
        else
        begin : g_none
            assign press_mask[i]  = 1'b0;
            assign repeat_mask[i] = 1'b0;
        end
    end

    assign slot_free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (m_tready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= {repeat_mask, press_mask};
            supp_reg <= suppressed;
        end
    end

    assign m_tvalid   = valid_reg;
    assign m_tdata    = data_reg;
    assign m_tuser[0] = supp_reg;

endmodule

[sv/button_auto_repeat.sv]
// ---------------------------------------------------------------------------
// button_auto_repeat
// per-button typematic key repeat with combo suppression
// ---------------------------------------------------------------------------
//
//  channel  | dir | word                                   | side info
//  ---------+-----+----------------------------------------+----------------
//  s_*      | in  | [15:0] button_mask, [63:16] sample_time| -
//  m_*      | out | [15:0] press_mask, [31:16] repeat_mask | tuser[0] suppressed
//  cfg_*    | in  | index 0..3, 24 bit data                | always ready
//
//  one sample per cycle unless the output stalls: every button lane updates its
//  state in the cycle of acceptance with a single subtract and compare, and the
//  merged result is registered in one output register
//  input is taken whenever the output register is empty or being emptied,
//  so a stall on the master side holds the input off only while it lasts
//  reset clears the lane flags and the output valid; timestamps need no clear
//
module button_auto_repeat
    import bar_pkg::*;
#(
    parameter int BUTTON_COUNT = 16,
    parameter int TIME_WIDTH   = 48
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // sample stream: [15:0] button_mask, [63:16] sample_time
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [63:0]           s_tdata,
    // result stream: [15:0] press_mask, [31:16] repeat_mask
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [2*MASK_W-1:0]   m_tdata,
    // result flags: [0] suppressed
    output logic [0:0]            m_tuser,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [DUR_W-1:0]      cfg_data
);

    // configuration registers
    logic [DUR_W-1:0] long_press_reg;
    logic [DUR_W-1:0] repeat_reg;
    logic [IDX_W-1:0] combo_first_reg;
    logic [IDX_W-1:0] combo_second_reg;

    logic [MASK_W-1:0]      button_mask;
    logic [SAMPLE_W-1:0]    sample_time;
    logic [TIME_WIDTH-1:0]  t;
    logic                   accept;
    logic                   suppressed;
    logic                   slot_free;
    bar_cfg_t               lane_cfg;
    bar_evt_t [BUTTON_COUNT-1:0] evt;

    assign button_mask = s_tdata[MASK_W-1:0];
    assign sample_time = s_tdata[MASK_W +: SAMPLE_W];

    // timestamp taken modulo 2^TIME_WIDTH
    if (TIME_WIDTH > SAMPLE_W)
    begin : g_time_ext
        assign t = {{(TIME_WIDTH-SAMPLE_W){1'b0}}, sample_time};
    end
    else
    begin : g_time_cut
        assign t = sample_time[TIME_WIDTH-1:0];
    end

    // config always taken; unknown indexes fall through
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_reg   <= LONG_PRESS_RESET;
            repeat_reg       <= REPEAT_RESET;
            combo_first_reg  <= COMBO_FIRST_RESET;
            combo_second_reg <= COMBO_SECOND_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_LONG_PRESS:   long_press_reg   <= cfg_data;
                REG_REPEAT:       repeat_reg       <= cfg_data;
                REG_COMBO_FIRST:  combo_first_reg  <= cfg_data[IDX_W-1:0];
                REG_COMBO_SECOND: combo_second_reg <= cfg_data[IDX_W-1:0];
                default:          ;
            endcase
        end
    end

    assign lane_cfg.long_press_us = long_press_reg;
    assign lane_cfg.repeat_us     = repeat_reg;

    assign s_tready = slot_free;
    assign accept   = s_tvalid && s_tready;

    // combo held: lanes keep their state and report nothing
    assign suppressed = button_mask[combo_first_reg] && button_mask[combo_second_reg];

    for (genvar i = 0; i < BUTTON_COUNT; i++)
    begin : g_lane
        logic down;
        // buttons past the mask width always read released
        if (i < MASK_W)
        begin : g_in
            assign down = button_mask[i];
        end
        else
        begin : g_out
            assign down = 1'b0;
        end

        bar_lane #(
            .TIME_WIDTH (TIME_WIDTH)
        ) u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (accept && !suppressed),
            .down  (down),
            .t     (t),
            .cfg   (lane_cfg),
            .evt   (evt[i])
        );
    end

    bar_merge #(
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .suppressed (suppressed),
        .evt        (evt),
        .slot_free  (slot_free),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

[sv/bar_checker.sv]
// ---------------------------------------------------------------------------
// bar_checker
// port-level assertions on the button auto-repeat block
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bar_checker
    import bar_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [2*MASK_W-1:0]   m_tdata,
    input  logic [0:0]            m_tuser
);

    `BAR_ASSERT_NEXT(a_out_holds, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `BAR_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
    `BAR_ASSERT_NEXT(a_one_result, s_tvalid && s_tready, m_tvalid, "accepted sample gave no result")
    `BAR_ASSERT(a_supp_quiet, !(m_tvalid && m_tuser[0]) || (m_tdata == '0), "suppressed result carries events")
    `BAR_ASSERT(a_excl_events, !m_tvalid || ((m_tdata[MASK_W-1:0] & m_tdata[2*MASK_W-1:MASK_W]) == '0), "press and repeat on one button")

endmodule

bind button_auto_repeat bar_checker u_bar_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
